@@ hw/rtl/second_order_pixel_predictor_macros.svh @@
// Assertion helpers for the pixel predictor. Both expand to nothing in synthesis.
`ifndef SECOND_ORDER_PIXEL_PREDICTOR_MACROS_SVH
`define SECOND_ORDER_PIXEL_PREDICTOR_MACROS_SVH

`ifndef SYNTHESIS
`define SOPP_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define SOPP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define SOPP_ASSERT_IMPLY(lbl, ante, cons)
`define SOPP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/sopp_pkg.sv @@
package sopp_pkg;

	localparam int MAX_BLOCK_WIDTH_DEF = 64;
	localparam int SAMPLE_BITS_DEF     = 16;

	localparam int DATA_BITS  = 18;
	localparam int TDATA_BITS = 24;
	localparam int FIELD_MAX  = 131071;
	localparam int FIELD_MIN  = -131072;

	localparam int BW_BITS   = 7;
	localparam int BH_BITS   = 11;
	localparam int ROW_BITS  = 10;
	localparam int ROW_LIMIT = 1024;
	localparam int CFG_INDEX_BITS = 2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_MODE         = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_WIDTH  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_HEIGHT = 2'd2;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// Position of a pixel inside its block, as the predictor needs it.
	typedef struct packed {
		logic x_zero;
		logic y_zero;
		logic x_ge2;
		logic y_ge2;
		logic row_end;
		logic blk_end;
	} pos_t;

endpackage

@@ hw/rtl/sopp_row_mem.sv @@
module sopp_row_mem #(
	parameter int MAX_BLOCK_WIDTH = sopp_pkg::MAX_BLOCK_WIDTH_DEF,
	parameter int SAMPLE_BITS     = sopp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_BLOCK_WIDTH)-1:0] wr_addr,
	input  logic [2*SAMPLE_BITS-1:0]     wr_data,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_BLOCK_WIDTH)-1:0] rd_addr,
	output logic [2*SAMPLE_BITS-1:0]     rd_data
);

	// Each entry holds {two rows above, one row above} for one column.
	logic [2*SAMPLE_BITS-1:0] mem [MAX_BLOCK_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/sopp_predict.sv @@
module sopp_predict #(
	parameter int SAMPLE_BITS = sopp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                mode,
	input  sopp_pkg::pos_t                      pos,
	input  logic signed [sopp_pkg::DATA_BITS-1:0] din,
	input  logic [SAMPLE_BITS-1:0]              west_one,
	input  logic [SAMPLE_BITS-1:0]              west_two,
	input  logic [SAMPLE_BITS-1:0]              north,
	input  logic [SAMPLE_BITS-1:0]              north_two,
	output logic [SAMPLE_BITS-1:0]              sample,
	output logic signed [sopp_pkg::DATA_BITS-1:0] result,
	output logic                                sat
);

	localparam int CW = ((SAMPLE_BITS > sopp_pkg::DATA_BITS) ?
		SAMPLE_BITS : sopp_pkg::DATA_BITS) + 3;
	localparam logic signed [CW-1:0] SMAX = CW'({SAMPLE_BITS{1'b1}});
	localparam logic signed [CW-1:0] FMAX = CW'(sopp_pkg::FIELD_MAX);
	localparam logic signed [CW-1:0] FMIN = CW'(sopp_pkg::FIELD_MIN);

	logic [SAMPLE_BITS-1:0] ww;
	logic [SAMPLE_BITS-1:0] nn;
	logic signed [CW-1:0]   w_x, ww_x, n_x, nn_x, ww_h, nn_h;
	logic signed [CW-1:0]   pred, din_x, sum, smp, res;

	always_comb begin
		// A missing second neighbor is replaced by the first one.
		ww   = pos.x_ge2 ? west_two : west_one;
		nn   = pos.y_ge2 ? north_two : north;
		w_x  = CW'({1'b0, west_one});
		ww_x = CW'({1'b0, ww});
		n_x  = CW'({1'b0, north});
		nn_x = CW'({1'b0, nn});
		// Samples are non-negative, so the shift truncates toward zero.
		ww_h = CW'({1'b0, ww >> 1});
		nn_h = CW'({1'b0, nn >> 1});

		if (pos.x_zero && pos.y_zero) begin
			pred = '0;
		end else if (pos.y_zero) begin
			pred = (w_x <<< 1) - ww_x;
		end else if (pos.x_zero) begin
			pred = (n_x <<< 1) - nn_x;
		end else begin
			pred = w_x - ww_h + n_x - nn_h;
		end

		din_x = CW'(din);
		sat   = 1'b0;
		if (mode == sopp_pkg::MODE_DECODE) begin
			sum = pred + din_x;
			if (sum < 0) begin
				smp = '0;
				sat = 1'b1;
			end else if (sum > SMAX) begin
				smp = SMAX;
				sat = 1'b1;
			end else begin
				smp = sum;
			end
			res = smp;
		end else begin
			sum = '0;
			if (din_x < 0) begin
				smp = '0;
			end else if (din_x > SMAX) begin
				smp = SMAX;
			end else begin
				smp = din_x;
			end
			res = smp - pred;
			if (res > FMAX) begin
				res = FMAX;
			end else if (res < FMIN) begin
				res = FMIN;
			end
		end

		sample = smp[SAMPLE_BITS-1:0];
		result = res[sopp_pkg::DATA_BITS-1:0];
	end

endmodule

@@ hw/rtl/second_order_pixel_predictor.sv @@
// Second-order pixel predictor for blocks of image samples in raster order.
// Slave stream: one request per pixel; s_tdata[17:0] carries a sample (encode)
// or a residual (decode). Master stream: one request per pixel; m_tdata[17:0]
// carries the residual (encode) or the reconstructed sample (decode), m_tlast
// marks the last pixel of a block and m_tuser flags a clamped decoded sample.
// The cfg port sets mode, block width and block height; write it only while
// no pixel is in flight.
// A request accepted into the input stage moves on to the output register,
// which presents it on the master side. Throughput is one pixel per cycle
// while the receiver does not stall; the limit is the west feedback loop that
// predicts, adds, clamps and writes back one sample to the west register.
// The row buffer is a single-port-write, single-port-read memory read when a
// pixel is accepted; a pixel that reads the column just being written gets
// the fresh value through a bypass register.
// Reset returns the configuration to encode mode with 8 x 8 blocks and clears
// the position counters, the west registers and the valid flags. The row
// buffer is not cleared; the first two rows of a block never use stale
// contents. When the receiver stalls, the result waits in the output register
// while one more request is taken into the input stage; s_tready then falls
// until the result drains.
module second_order_pixel_predictor #(
	parameter int MAX_BLOCK_WIDTH = sopp_pkg::MAX_BLOCK_WIDTH_DEF,
	parameter int SAMPLE_BITS     = sopp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write port.
	input  logic                                  cfg_wen,
	input  logic [sopp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [sopp_pkg::BH_BITS-1:0]          cfg_wdata,
	// Input stream.
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [sopp_pkg::TDATA_BITS-1:0]       s_tdata,   // [17:0] data_in
	// Output stream.
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [sopp_pkg::TDATA_BITS-1:0]       m_tdata,   // [17:0] data_out
	output logic                                  m_tlast,   // block_end
	output logic                                  m_tuser    // [0] saturated
);

	`include "second_order_pixel_predictor_macros.svh"

	localparam int CXW = $clog2(MAX_BLOCK_WIDTH);
	localparam int LW  = (CXW + 1 > sopp_pkg::BW_BITS) ? CXW + 1 : sopp_pkg::BW_BITS;
	localparam int DB  = sopp_pkg::DATA_BITS;

	// Configuration registers.
	logic                          mode_q;
	logic [sopp_pkg::BW_BITS-1:0]  bw_q;
	logic [sopp_pkg::BH_BITS-1:0]  bh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sopp_pkg::MODE_ENCODE;
			bw_q   <= sopp_pkg::BW_BITS'(8);
			bh_q   <= sopp_pkg::BH_BITS'(8);
		end else if (cfg_wen) begin
			case (cfg_index)
				sopp_pkg::REG_MODE:         mode_q <= cfg_wdata[0];
				sopp_pkg::REG_BLOCK_WIDTH:  bw_q   <= cfg_wdata[sopp_pkg::BW_BITS-1:0];
				sopp_pkg::REG_BLOCK_HEIGHT: bh_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Handshake: the input stage frees up whenever its pixel moves on.
	logic v_s1, out_v_q, fire, accept;

	assign fire     = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !v_s1 || fire;
	assign accept   = s_tvalid && s_tready;

	// Position counters, advanced on every accepted pixel.
	logic [CXW-1:0]                 col_q;
	logic [sopp_pkg::ROW_BITS-1:0]  row_q;
	logic [LW-1:0]                  col_next, w_eff;
	logic [sopp_pkg::BH_BITS-1:0]   row_next, h_eff;
	sopp_pkg::pos_t                 pos;

	always_comb begin
		if (bw_q == '0) begin
			w_eff = LW'(1);
		end else if (LW'(bw_q) > LW'(MAX_BLOCK_WIDTH)) begin
			w_eff = LW'(MAX_BLOCK_WIDTH);
		end else begin
			w_eff = LW'(bw_q);
		end
		if (bh_q == '0) begin
			h_eff = sopp_pkg::BH_BITS'(1);
		end else if (bh_q > sopp_pkg::BH_BITS'(sopp_pkg::ROW_LIMIT)) begin
			h_eff = sopp_pkg::BH_BITS'(sopp_pkg::ROW_LIMIT);
		end else begin
			h_eff = bh_q;
		end
		col_next    = LW'(col_q) + LW'(1);
		row_next    = sopp_pkg::BH_BITS'(row_q) + sopp_pkg::BH_BITS'(1);
		pos.x_zero  = (col_q == '0);
		pos.y_zero  = (row_q == '0);
		pos.x_ge2   = (LW'(col_q) > LW'(1));
		pos.y_ge2   = (row_q > sopp_pkg::ROW_BITS'(1));
		pos.row_end = (col_next >= w_eff);
		pos.blk_end = pos.row_end && (row_next >= h_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (pos.row_end) begin
				col_q <= '0;
				row_q <= pos.blk_end ? '0 : row_next[sopp_pkg::ROW_BITS-1:0];
			end else begin
				col_q <= col_next[CXW-1:0];
			end
		end
	end

	// Input stage.
	logic signed [DB-1:0]     din_s1;
	logic [CXW-1:0]           x_s1;
	sopp_pkg::pos_t           pos_s1;
	logic                     byp_s1;
	logic [SAMPLE_BITS-1:0]   byp_n_s1, byp_nn_s1;
	logic [2*SAMPLE_BITS-1:0] rd_data;
	logic [SAMPLE_BITS-1:0]   north, north_two;
	logic [SAMPLE_BITS-1:0]   west_one_q, west_two_q;
	logic [SAMPLE_BITS-1:0]   sample_c;
	logic signed [DB-1:0]     result_c;
	logic                     sat_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	// The pixel leaving the input stage writes the column that the incoming
	// pixel reads when both sit in the same column (a block one pixel wide);
	// the fresh values are then taken from the bypass registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			din_s1    <= s_tdata[DB-1:0];
			x_s1      <= col_q;
			pos_s1    <= pos;
			byp_s1    <= fire && (x_s1 == col_q);
			byp_n_s1  <= sample_c;
			byp_nn_s1 <= north;
		end
	end

	sopp_row_mem #(
		.MAX_BLOCK_WIDTH (MAX_BLOCK_WIDTH),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_row_mem (
		.clk     (clk),
		.wr_en   (fire),
		.wr_addr (x_s1),
		.wr_data ({north, sample_c}),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_data)
	);

	assign north     = byp_s1 ? byp_n_s1  : rd_data[SAMPLE_BITS-1:0];
	assign north_two = byp_s1 ? byp_nn_s1 : rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];

	sopp_predict #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_predict (
		.mode      (mode_q),
		.pos       (pos_s1),
		.din       (din_s1),
		.west_one  (west_one_q),
		.west_two  (west_two_q),
		.north     (north),
		.north_two (north_two),
		.sample    (sample_c),
		.result    (result_c),
		.sat       (sat_c)
	);

	// West neighbors follow the pixel leaving the input stage and restart at
	// each row end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			west_one_q <= '0;
			west_two_q <= '0;
		end else if (fire) begin
			if (pos_s1.row_end) begin
				west_one_q <= '0;
				west_two_q <= '0;
			end else begin
				west_one_q <= sample_c;
				west_two_q <= west_one_q;
			end
		end
	end

	// Output register.
	logic signed [DB-1:0] data_s2;
	logic                 last_s2, sat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (fire) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			data_s2 <= result_c;
			last_s2 <= pos_s1.blk_end;
			sat_s2  <= sat_c;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(sopp_pkg::TDATA_BITS - DB){1'b0}}, data_s2};
	assign m_tlast  = last_s2;
	assign m_tuser  = sat_s2;

	// A row end sends the column counter back to the first column.
	`SOPP_ASSERT_NEXT(a_row_wrap, accept && pos.row_end, col_q == '0)
	// The first pixel of a row sees cleared west neighbors.
	`SOPP_ASSERT_IMPLY(a_west_clear, v_s1 && pos_s1.x_zero, west_one_q == '0 && west_two_q == '0)
	// Only decoding raises the flag for a clamped sample.
	`SOPP_ASSERT_IMPLY(a_sat_decode, m_tvalid && m_tuser, mode_q == sopp_pkg::MODE_DECODE)

endmodule
